>>> sv/rcfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the remote control frame builder.
package rcfb_pkg;

	localparam int SAMPLE_W = 12;
	localparam int BYTE_W   = 8;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 40;

	typedef enum logic [BYTE_W-1:0] {
		CMD_SELECT = 8'hAA,
		CMD_IDLE   = 8'hBB,
		CMD_MAIN   = 8'hCC
	} cmd_t;

	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo_edge;
		logic [SAMPLE_W-1:0] hi_edge;
		logic [SAMPLE_W-1:0] lo_stop;
		logic [SAMPLE_W-1:0] hi_stop;
		logic [31:0]         mul_lo;
		logic [5:0]          sh_lo;
		logic [31:0]         mul_hi;
		logic [5:0]          sh_hi;
	} axis_cfg_t;

	// d * 1848 / travel as (d * mul) >> sh, exact over the clamped travel
	localparam axis_cfg_t X_CFG = '{
		lo_edge: 12'd1300, hi_edge: 12'd1700, lo_stop: 12'd950, hi_stop: 12'd2050,
		mul_lo: 32'd2834678616, sh_lo: 6'd29,
		mul_hi: 32'd2834678616, sh_hi: 6'd29
	};

	localparam axis_cfg_t Y_CFG = '{
		lo_edge: 12'd3100, hi_edge: 12'd3500, lo_stop: 12'd2600, hi_stop: 12'd3700,
		mul_lo: 32'd1984275216, sh_lo: 6'd29,
		mul_hi: 32'd2480344944, sh_hi: 6'd28
	};

	localparam logic [12:0] MID_SCALE = 13'd2048;
	localparam logic [12:0] START_HI  = 13'd2248;
	localparam logic [12:0] START_LO  = 13'd1848;

	localparam logic [SAMPLE_W-1:0] SLIDE_CEIL  = 12'd2496;
	localparam logic [SAMPLE_W-1:0] SLIDE_FLOOR = 12'd400;
	// v * 4096 / 2496 as (v * SLIDE_MUL) >> SLIDE_SH
	localparam logic [18:0]         SLIDE_MUL   = 19'd430186;
	localparam int                  SLIDE_SH    = 18;

	function automatic logic [BYTE_W-1:0] sat_byte(input logic [12:0] v);
		logic [BYTE_W-1:0] r;
		r = v[12] ? 8'hFF : v[11:4];
		return r;
	endfunction

endpackage

>>> sv/rcfb_axis.sv
`timescale 1ns / 1ps
// Joystick axis dead zone, clamp and scaling to one byte.
module rcfb_axis #(
	parameter rcfb_pkg::axis_cfg_t CFG = rcfb_pkg::X_CFG
) (
	input  logic                              clk,
	input  rcfb_pkg::stage_en_t               en,
	input  logic [rcfb_pkg::SAMPLE_W-1:0]     sample_s1,
	output logic [rcfb_pkg::BYTE_W-1:0]       byte_s3
);

	logic [rcfb_pkg::SAMPLE_W-1:0] vc;
	logic                          in_zone;
	logic                          low_side;
	logic [8:0]                    offset;

	logic       in_zone_s2;
	logic       low_s2;
	logic [8:0] offset_s2;

	logic [40:0] prod;
	logic [10:0] quo;
	logic [12:0] val;

	always_comb begin
		in_zone = (sample_s1 > CFG.lo_edge) && (sample_s1 < CFG.hi_edge);
		if (sample_s1 < CFG.lo_stop) begin
			vc = CFG.lo_stop;
		end else if (sample_s1 > CFG.hi_stop) begin
			vc = CFG.hi_stop;
		end else begin
			vc = sample_s1;
		end
		low_side = (vc <= CFG.lo_edge);
		offset = low_side ? 9'(CFG.lo_edge - vc) : 9'(vc - CFG.hi_edge);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			in_zone_s2 <= in_zone;
			low_s2     <= low_side;
			offset_s2  <= offset;
		end
	end

	always_comb begin
		if (low_s2) begin
			prod = 41'(offset_s2) * 41'(CFG.mul_lo);
			quo  = 11'(prod >> CFG.sh_lo);
			val  = rcfb_pkg::START_HI + 13'(quo);
		end else begin
			prod = 41'(offset_s2) * 41'(CFG.mul_hi);
			quo  = 11'(prod >> CFG.sh_hi);
			val  = rcfb_pkg::START_LO - 13'(quo);
		end
		if (in_zone_s2) begin
			val = rcfb_pkg::MID_SCALE;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			byte_s3 <= rcfb_pkg::sat_byte(val);
		end
	end

endmodule

>>> sv/rcfb_slide.sv
`timescale 1ns / 1ps
// Slider clamp, floor and scaling to one byte.
module rcfb_slide (
	input  logic                          clk,
	input  rcfb_pkg::stage_en_t           en,
	input  logic [rcfb_pkg::SAMPLE_W-1:0] sample_s1,
	output logic [rcfb_pkg::BYTE_W-1:0]   byte_s3
);

	logic [rcfb_pkg::SAMPLE_W-1:0] vc;
	logic [rcfb_pkg::SAMPLE_W-1:0] v_s2;
	logic [30:0]                   prod;
	logic [12:0]                   val;

	always_comb begin
		if (sample_s1 > rcfb_pkg::SLIDE_CEIL) begin
			vc = rcfb_pkg::SLIDE_CEIL;
		end else if (sample_s1 < rcfb_pkg::SLIDE_FLOOR) begin
			vc = '0;
		end else begin
			vc = sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			v_s2 <= vc;
		end
	end

	always_comb begin
		prod = 31'(v_s2) * 31'(rcfb_pkg::SLIDE_MUL);
		val  = 13'(prod >> rcfb_pkg::SLIDE_SH);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			byte_s3 <= rcfb_pkg::sat_byte(val);
		end
	end

endmodule

>>> sv/remote_control_frame_builder_unit.sv
`timescale 1ns / 1ps
// A result is valid once its item has passed the input, offset and result registers.
// Throughput: one item per cycle while the output takes results; three register stages
// (input, offset, result) each advance whenever they are empty or the stage after them advances.
// An item is taken while a result waits as long as an earlier stage is empty.
// Reset clears the stage valid bits only; data registers are not reset.
// Top level of the remote control frame builder.
module remote_control_frame_builder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// select_pressed, main_pressed, slide_sample, horiz_sample, vert_sample,
	// aux_sample, zero fill
	input  logic [rcfb_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// command_byte, slide_byte, horiz_byte, vert_byte, aux_byte
	output logic [rcfb_pkg::OUT_W-1:0] m_axis_tdata
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic adv_s1;
	logic adv_s2;
	logic adv_s3;

	rcfb_pkg::stage_en_t en;

	logic [rcfb_pkg::IN_W-1:0] data_s1;

	rcfb_pkg::cmd_t             cmd;
	rcfb_pkg::cmd_t             cmd_s2;
	rcfb_pkg::cmd_t             cmd_s3;
	logic [rcfb_pkg::BYTE_W-1:0] aux_s2;
	logic [rcfb_pkg::BYTE_W-1:0] aux_s3;
	logic [rcfb_pkg::BYTE_W-1:0] slide_s3;
	logic [rcfb_pkg::BYTE_W-1:0] horiz_s3;
	logic [rcfb_pkg::BYTE_W-1:0] vert_s3;

	assign adv_s3 = !valid_s3 || m_axis_tready;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign en.s2 = adv_s2;
	assign en.s3 = adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		if (data_s1[1]) begin
			cmd = rcfb_pkg::CMD_MAIN;
		end else if (data_s1[0]) begin
			cmd = rcfb_pkg::CMD_SELECT;
		end else begin
			cmd = rcfb_pkg::CMD_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cmd_s2 <= cmd;
			aux_s2 <= data_s1[49:42];
		end
		if (adv_s3) begin
			cmd_s3 <= cmd_s2;
			aux_s3 <= aux_s2;
		end
	end

	rcfb_slide u_slide (
		.clk       (clk),
		.en        (en),
		.sample_s1 (data_s1[13:2]),
		.byte_s3   (slide_s3)
	);

	rcfb_axis #(
		.CFG (rcfb_pkg::X_CFG)
	) u_horiz (
		.clk       (clk),
		.en        (en),
		.sample_s1 (data_s1[25:14]),
		.byte_s3   (horiz_s3)
	);

	rcfb_axis #(
		.CFG (rcfb_pkg::Y_CFG)
	) u_vert (
		.clk       (clk),
		.en        (en),
		.sample_s1 (data_s1[37:26]),
		.byte_s3   (vert_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {aux_s3, vert_s3, horiz_s3, slide_s3, cmd_s3};

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted item not held in input stage");

	a_s2_moves_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && adv_s3) |=> valid_s3)
		else $error("item lost between offset and result stage");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2 && adv_s3) |=> !valid_s3)
		else $error("result appeared without an item behind it");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] == rcfb_pkg::CMD_SELECT
			|| m_axis_tdata[7:0] == rcfb_pkg::CMD_IDLE
			|| m_axis_tdata[7:0] == rcfb_pkg::CMD_MAIN))
		else $error("command byte outside its codes");

endmodule

>>> tb/tb_remote_control_frame_builder_unit.sv
`timescale 1ns / 1ps
// Testbench of the remote control frame builder: directed rows, random panels, scoreboard.
module tb_remote_control_frame_builder_unit;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DIR_ROWS     = 20;
	localparam int DEAD_BAND    = 200;
	localparam int KICK         = 200;
	localparam int STICK_MID    = 2048;
	localparam int STICK_SPAN   = 1848;
	localparam int FULL_RANGE   = 4096;
	localparam int SLIDE_TOP    = 2496;
	localparam int SLIDE_BOTTOM = 400;
	localparam int X_REST       = 1500;
	localparam int X_REACH      = 350;
	localparam int Y_REST       = 3300;
	localparam int Y_REACH_LO   = 500;
	localparam int Y_REACH_HI   = 200;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [11:0] aux;
		logic [11:0] vert;
		logic [11:0] horiz;
		logic [11:0] slide;
		logic        main_b;
		logic        select_b;
	} panel_in_t;

	typedef struct packed {
		logic [7:0] aux_b;
		logic [7:0] vert_b;
		logic [7:0] horiz_b;
		logic [7:0] slide_b;
		logic [7:0] cmd_b;
	} frame_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [rcfb_pkg::IN_W-1:0]  s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [rcfb_pkg::OUT_W-1:0] m_axis_tdata;

	bit     pin_typed;
	frame_t pin_want;
	frame_t frame_q[$];
	int     err_count;
	int     n_sent;
	int     n_checked;
	int     cycles;
	bit     tx_gaps;
	bit     rx_quiet;
	bit     rx_hold;
	bit     rx_holding;

	panel_in_t dir_in[DIR_ROWS];
	bit        dir_typed[DIR_ROWS];
	frame_t    dir_want[DIR_ROWS];

	remote_control_frame_builder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic logic [7:0] byte_of(int v);
		int q;
		q = v / 16;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic int stick_level(int v, int rest, int reach_lo, int reach_hi);
		int lo_edge;
		int hi_edge;
		int c;
		lo_edge = rest - DEAD_BAND;
		hi_edge = rest + DEAD_BAND;
		c = v;
		if (c > lo_edge && c < hi_edge)
			return STICK_MID;
		if (c < lo_edge - reach_lo)
			c = lo_edge - reach_lo;
		else if (c > hi_edge + reach_hi)
			c = hi_edge + reach_hi;
		if (c <= lo_edge)
			return STICK_MID + KICK + (lo_edge - c) * STICK_SPAN / reach_lo;
		return STICK_MID - KICK - (c - hi_edge) * STICK_SPAN / reach_hi;
	endfunction

	function automatic frame_t frame_of(panel_in_t p);
		frame_t         f;
		rcfb_pkg::cmd_t c;
		int             s;
		if (p.main_b)
			c = rcfb_pkg::CMD_MAIN;
		else if (p.select_b)
			c = rcfb_pkg::CMD_SELECT;
		else
			c = rcfb_pkg::CMD_IDLE;
		s = p.slide;
		if (s > SLIDE_TOP)
			s = SLIDE_TOP;
		else if (s < SLIDE_BOTTOM)
			s = 0;
		f.cmd_b   = c;
		f.slide_b = byte_of(s * FULL_RANGE / SLIDE_TOP);
		f.horiz_b = byte_of(stick_level(p.horiz, X_REST, X_REACH, X_REACH));
		f.vert_b  = byte_of(stick_level(p.vert, Y_REST, Y_REACH_LO, Y_REACH_HI));
		f.aux_b   = byte_of(p.aux);
		return f;
	endfunction

	function automatic panel_in_t mk(bit sel, bit mb, int sl, int h, int v, int a);
		panel_in_t p;
		p.select_b = sel;
		p.main_b   = mb;
		p.slide    = sl[11:0];
		p.horiz    = h[11:0];
		p.vert     = v[11:0];
		p.aux      = a[11:0];
		return p;
	endfunction

	function automatic frame_t mk_frame(rcfb_pkg::cmd_t c, int sl, int h, int v, int a);
		frame_t f;
		f.cmd_b   = c;
		f.slide_b = sl[7:0];
		f.horiz_b = h[7:0];
		f.vert_b  = v[7:0];
		f.aux_b   = a[7:0];
		return f;
	endfunction

	function automatic int near(int pt);
		int r;
		r = pt + $urandom_range(0, 6) - 3;
		if (r < 0)
			r = 0;
		if (r > 4095)
			r = 4095;
		return r;
	endfunction

	function automatic int pick_stick(int rest, int reach_lo, int reach_hi);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 4095);
			1: return near($urandom_range(0, 1) ? rest - DEAD_BAND : rest + DEAD_BAND);
			2: return near($urandom_range(0, 1) ? rest - DEAD_BAND - reach_lo
				: rest + DEAD_BAND + reach_hi);
			default: return $urandom_range(rest - DEAD_BAND - reach_lo,
				rest + DEAD_BAND + reach_hi);
		endcase
	endfunction

	function automatic panel_in_t rand_panel();
		int sl;
		int a;
		case ($urandom_range(0, 3))
			0: sl = near($urandom_range(0, 1) ? SLIDE_BOTTOM : SLIDE_TOP);
			1: sl = $urandom_range(0, 1) ? 0 : 4095;
			default: sl = $urandom_range(0, 4095);
		endcase
		a = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : 4095)
			: $urandom_range(0, 4095);
		return mk($urandom_range(0, 1), $urandom_range(0, 1), sl,
			pick_stick(X_REST, X_REACH, X_REACH),
			pick_stick(Y_REST, Y_REACH_LO, Y_REACH_HI), a);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		if (err_count < 30)
			$display("mismatch on frame %0d: %s got %0d expected %0d",
				n_checked, field, got, want);
		err_count++;
	endtask

	task automatic check_frame(frame_t got, frame_t want);
		if (got.cmd_b !== want.cmd_b)
			report_mismatch("command_byte", got.cmd_b, want.cmd_b);
		if (got.slide_b !== want.slide_b)
			report_mismatch("slide_byte", got.slide_b, want.slide_b);
		if (got.horiz_b !== want.horiz_b)
			report_mismatch("horiz_byte", got.horiz_b, want.horiz_b);
		if (got.vert_b !== want.vert_b)
			report_mismatch("vert_byte", got.vert_b, want.vert_b);
		if (got.aux_b !== want.aux_b)
			report_mismatch("aux_byte", got.aux_b, want.aux_b);
	endtask

	task automatic offer(panel_in_t p, bit typed, frame_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(rcfb_pkg::IN_W - 50){1'b0}}, p};
		pin_typed     <= typed;
		pin_want      <= want;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic maybe_gap();
		logic [63:0] junk;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			junk = {$urandom, $urandom};
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= junk[rcfb_pkg::IN_W-1:0];
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d frames pending", cycles, frame_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// check the output side first so a new item never pairs with an older result
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_q.size() == 0) begin
					report_mismatch("unexpected frame", m_axis_tdata[31:0], 0);
				end else begin
					check_frame(m_axis_tdata, frame_q.pop_front());
				end
				n_checked++;
			end
			if (s_axis_tvalid && s_axis_tready)
				frame_q.push_back(pin_typed ? pin_want : frame_of(s_axis_tdata[49:0]));
		end
	end

	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold) begin
				rx_holding = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
				rx_holding = 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat (rx_quiet ? 1 : $urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		pin_typed     = 1'b0;
		pin_want      = '0;
		tx_gaps       = 1'b1;

		dir_in[0]  = mk(0, 0, 0, 0, 0, 0);
		dir_in[1]  = mk(1, 1, 4095, 4095, 4095, 4095);
		dir_in[2]  = mk(1, 0, 0, 1500, 3300, 0);
		dir_in[3]  = mk(0, 1, 0, 1500, 3300, 0);
		dir_in[4]  = mk(0, 0, 399, 1300, 3100, 15);
		dir_in[5]  = mk(1, 0, 400, 1301, 3101, 16);
		dir_in[6]  = mk(0, 1, 2495, 1699, 3499, 4079);
		dir_in[7]  = mk(1, 1, 2496, 1700, 3500, 4080);
		dir_in[8]  = mk(0, 0, 2497, 950, 2600, 12'hAAA);
		dir_in[9]  = mk(1, 0, 1000, 949, 2599, 12'h555);
		dir_in[10] = mk(0, 1, 2000, 951, 2601, 1);
		dir_in[11] = mk(0, 0, 1248, 2050, 3700, 2048);
		dir_in[12] = mk(1, 0, 401, 2051, 3701, 2047);
		dir_in[13] = mk(0, 0, 398, 2049, 3699, 4094);
		dir_in[14] = mk(0, 0, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
		dir_in[15] = mk(1, 1, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
		dir_in[16] = mk(0, 0, 1, 1, 1, 1);
		dir_in[17] = mk(0, 0, 4094, 4094, 4094, 4094);
		dir_in[18] = mk(0, 1, 0, 1200, 3000, 0);
		dir_in[19] = mk(1, 0, 0, 1800, 3600, 0);
		for (int i = 0; i < DIR_ROWS; i++) begin
			dir_typed[i] = 1'b0;
			dir_want[i]  = '0;
		end
		dir_typed[0] = 1'b1;
		dir_want[0]  = mk_frame(rcfb_pkg::CMD_IDLE, 0, 255, 255, 0);
		dir_typed[1] = 1'b1;
		dir_want[1]  = mk_frame(rcfb_pkg::CMD_MAIN, 255, 0, 0, 255);
		dir_typed[2] = 1'b1;
		dir_want[2]  = mk_frame(rcfb_pkg::CMD_SELECT, 0, 128, 128, 0);
		dir_typed[3] = 1'b1;
		dir_want[3]  = mk_frame(rcfb_pkg::CMD_MAIN, 0, 128, 128, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(dir_in[i], dir_typed[i], dir_want[i]);
			maybe_gap();
		end

		for (int i = 0; i < 1000; i++) begin
			offer(rand_panel(), 1'b0, '0);
			maybe_gap();
		end

		// stall the output for a long stretch while items keep coming
		s_axis_tvalid <= 1'b0;
		rx_hold = 1'b1;
		while (!rx_holding) @(posedge clk);
		for (int i = 0; i < 40; i++)
			offer(rand_panel(), 1'b0, '0);
		s_axis_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(posedge clk);

		for (int i = 0; i < 200; i++) begin
			offer(rand_panel(), 1'b0, '0);
			maybe_gap();
		end

		tx_gaps  = 1'b0;
		rx_quiet = 1'b1;
		for (int i = 0; i < 260; i++)
			offer(rand_panel(), 1'b0, '0);
		s_axis_tvalid <= 1'b0;

		while (frame_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d sample sets (button combinations, dead-zone and travel edges,",
			n_sent);
		$display("slider floor and ceiling, long output stall), checked %0d frames, %0d errors",
			n_checked, err_count);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/rcfb_pkg.sv
sv/rcfb_axis.sv
sv/rcfb_slide.sv
sv/remote_control_frame_builder_unit.sv
tb/tb_remote_control_frame_builder_unit.sv
